FILE: hdl/awb_pkg.sv
// Shared types and constants for the affine warp bilinear sampler.
`default_nettype none

package awb_pkg;

   // Command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 25;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_XX       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_XY       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_YX       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_YY       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd7;

   // Arithmetic widths
   localparam int WGT_W  = 33;  // bilinear weight, at most 2^32
   localparam int WA_W   = 49;  // weight times alpha and its sums
   localparam int PROD_W = 64;  // premultiplied colour terms and sums
   localparam int NUM_W  = 65;  // rounded dividend
   localparam int QBITS  = 17;  // quotient bits, one extra for saturation

   // Pipeline depths
   localparam int COORD_STAGES = 3;
   localparam int STORE_STAGES = 1;
   localparam int BLEND_STAGES = 6;
   localparam int DIV_STAGES   = QBITS;
   localparam int OUT_STAGES   = 1;

   typedef struct packed {
      logic [15:0] alpha;
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } pixel_type;

   typedef struct packed {
      logic signed [24:0] origin_x;
      logic signed [24:0] origin_y;
      logic signed [20:0] step_xx;
      logic signed [20:0] step_xy;
      logic signed [20:0] step_yx;
      logic signed [20:0] step_yy;
      logic [8:0]         source_width;
      logic [8:0]         source_height;
   } cfg_type;

   // Sample control travelling with the store read
   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        x_odd;
      logic        y_odd;
      logic [15:0] dx;
      logic [15:0] dy;
   } ctl_type;

   // Result side information travelling with the blend and divide
   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        zero;
      logic [15:0] alpha;
      pixel_type   pix;
   } side_type;

endpackage

`default_nettype wire

FILE: hdl/affine_warp_bilinear_sampler.sv
// Top level of the affine warp bilinear sampler: config, pipeline and result register.
`default_nettype none

// One transaction enters per clock while busy is low, writes and samples mixed
// freely, and a sample's result appears on the rsp_ ports after 3 mapping
// stages, 1 frame store read, 6 blend stages, 17 divider stages and 1 output
// register; writes produce no result. The depth is set by the 17-stage
// bit-per-stage colour divider. The frame store is four parity banks, so all
// four neighbors are read in the same cycle; a write takes effect in order with
// the samples around it. The store has no reset: a sample must only touch
// pixels that were written. busy is high during reset and clears on the first
// clock without reset, and results cannot be held off by the receiver.
// Configuration must be written while no sample is in flight.
module affine_warp_bilinear_sampler #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_start,
   output logic                                    busy,
   input  wire logic                               req_command,
   input  wire logic [7:0]                         req_column,
   input  wire logic [7:0]                         req_row,
   input  wire logic [15:0]                        req_red_in,
   input  wire logic [15:0]                        req_green_in,
   input  wire logic [15:0]                        req_blue_in,
   input  wire logic [15:0]                        req_alpha_in,
   input  wire logic                               csr_write,
   input  wire logic [awb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [awb_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                    rsp_strobe,
   output logic [15:0]                             rsp_red_out,
   output logic [15:0]                             rsp_green_out,
   output logic [15:0]                             rsp_blue_out,
   output logic [15:0]                             rsp_alpha_out
);
   import awb_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int LATENCY = COORD_STAGES + STORE_STAGES + BLEND_STAGES +
                            DIV_STAGES + OUT_STAGES;

   logic      busy_ff;
   logic      accept;
   pixel_type req_pixel;
   cfg_type   cfg_ff, cfg_in;

   ctl_type   coord_ctl, store_ctl;
   logic      coord_write;
   logic [XW-1:0] coord_x;
   logic [YW-1:0] coord_y;
   pixel_type coord_pixel;
   pixel_type store_q [4];

   side_type         blend_side, div_side;
   logic [NUM_W-1:0] blend_num [3];
   logic [WA_W-1:0]  blend_den;
   logic [QBITS-1:0] div_quo [3];

   logic        strobe_ff;
   pixel_type   out_ff, out_in;

   assign accept    = req_start && !busy_ff;
   assign req_pixel = {req_alpha_in, req_blue_in, req_green_in, req_red_in};

   // Configuration register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ORIGIN_X:      cfg_in.origin_x      = csr_data;
            REG_ORIGIN_Y:      cfg_in.origin_y      = csr_data;
            REG_STEP_XX:       cfg_in.step_xx       = csr_data[20:0];
            REG_STEP_XY:       cfg_in.step_xy       = csr_data[20:0];
            REG_STEP_YX:       cfg_in.step_yx       = csr_data[20:0];
            REG_STEP_YY:       cfg_in.step_yy       = csr_data[20:0];
            REG_SOURCE_WIDTH:  cfg_in.source_width  = csr_data[8:0];
            REG_SOURCE_HEIGHT: cfg_in.source_height = csr_data[8:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff              <= 1'b1;
         cfg_ff.origin_x      <= 25'(1 << (FRAC_BITS - 1));
         cfg_ff.origin_y      <= 25'(1 << (FRAC_BITS - 1));
         cfg_ff.step_xx       <= 21'(1 << FRAC_BITS);
         cfg_ff.step_xy       <= '0;
         cfg_ff.step_yx       <= '0;
         cfg_ff.step_yy       <= 21'(1 << FRAC_BITS);
         cfg_ff.source_width  <= 9'd256;
         cfg_ff.source_height <= 9'd256;
      end else begin
         busy_ff <= 1'b0;
         cfg_ff  <= cfg_in;
      end
   end

   awb_coord #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_coord (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_command (req_command),
      .in_column  (req_column),
      .in_row     (req_row),
      .in_pixel   (req_pixel),
      .cfg        (cfg_ff),
      .out_ctl    (coord_ctl),
      .out_write  (coord_write),
      .out_x      (coord_x),
      .out_y      (coord_y),
      .out_pixel  (coord_pixel)
   );

   awb_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (coord_ctl),
      .in_write (coord_write),
      .in_x     (coord_x),
      .in_y     (coord_y),
      .in_pixel (coord_pixel),
      .out_ctl  (store_ctl),
      .out_q    (store_q)
   );

   awb_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (store_ctl),
      .in_q     (store_q),
      .out_side (blend_side),
      .out_num  (blend_num),
      .out_den  (blend_den)
   );

   awb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_side  (blend_side),
      .in_num   (blend_num),
      .in_den   (blend_den),
      .out_side (div_side),
      .out_quo  (div_quo)
   );

   // Result select: exact hit, transparent black, or divided colour
   always_comb begin
      if (div_side.hit) begin
         out_in = div_side.pix;
      end else if (div_side.zero) begin
         out_in = '0;
      end else begin
         out_in.red   = div_quo[0][QBITS-1] ? 16'hFFFF : div_quo[0][15:0];
         out_in.green = div_quo[1][QBITS-1] ? 16'hFFFF : div_quo[1][15:0];
         out_in.blue  = div_quo[2][QBITS-1] ? 16'hFFFF : div_quo[2][15:0];
         out_in.alpha = div_side.alpha;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset)
         strobe_ff <= 1'b0;
      else
         strobe_ff <= div_side.valid;
   end

   assign busy          = busy_ff;
   assign rsp_strobe    = strobe_ff;
   assign rsp_red_out   = out_ff.red;
   assign rsp_green_out = out_ff.green;
   assign rsp_blue_out  = out_ff.blue;
   assign rsp_alpha_out = out_ff.alpha;

   // Every result comes from a sample accepted earlier, through the full pipeline
   a_result_from_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_start && !busy && req_command == CMD_SAMPLE, LATENCY))
      else $error("result without matching sample transaction");

   // A write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      $past(req_start && !busy && req_command == CMD_WRITE, LATENCY) |-> !rsp_strobe)
      else $error("write transaction produced a result");

   // Pipeline is empty while coming out of reset
   a_flush_on_reset: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result while pipeline should be flushed");

endmodule

`default_nettype wire

FILE: hdl/awb_coord.sv
// Affine coordinate mapping, clamping and split into index and fraction.
`default_nettype none

module awb_coord #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic                              in_command,
   input  wire logic [7:0]                        in_column,
   input  wire logic [7:0]                        in_row,
   input  wire awb_pkg::pixel_type                in_pixel,
   input  wire awb_pkg::cfg_type                  cfg,
   output awb_pkg::ctl_type                       out_ctl,
   output logic                                   out_write,
   output logic [$clog2(MAX_WIDTH)-1:0]           out_x,
   output logic [$clog2(MAX_HEIGHT)-1:0]          out_y,
   output awb_pkg::pixel_type                     out_pixel
);
   import awb_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int SW = 33;
   localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

   // Stage 1: products
   logic               v1_ff, cmd1_ff;
   logic [7:0]         col1_ff, row1_ff;
   pixel_type          pix1_ff;
   logic signed [29:0] pxc1_ff, pxr1_ff, pyc1_ff, pyr1_ff;
   logic signed [29:0] pxc1_in, pxr1_in, pyc1_in, pyr1_in;

   // Stage 2: sums
   logic                 v2_ff, cmd2_ff;
   logic [7:0]           col2_ff, row2_ff;
   pixel_type            pix2_ff;
   logic signed [SW-1:0] sx2_ff, sy2_ff, sx2_in, sy2_in;

   // Stage 3: clamp and split
   ctl_type        ctl3_ff, ctl3_in;
   logic           we3_ff, we3_in;
   logic [XW-1:0]  x3_ff, x3_in;
   logic [YW-1:0]  y3_ff, y3_in;
   pixel_type      pix3_ff;

   logic [8:0]           w_eff, h_eff;
   logic signed [SW-1:0] hi_x, hi_y, cx, cy;
   logic [FRAC_BITS-1:0] fx, fy;

   function automatic logic signed [SW-1:0] clamp_coord(logic signed [SW-1:0] v,
                                                        logic signed [SW-1:0] hi);
      logic signed [SW-1:0] t;
      t = v - HALF;
      if (t < 0)
         return '0;
      else if (t > hi)
         return hi;
      return t;
   endfunction

   always_comb begin
      pxc1_in = $signed({1'b0, in_column}) * cfg.step_xx;
      pxr1_in = $signed({1'b0, in_row}) * cfg.step_xy;
      pyc1_in = $signed({1'b0, in_column}) * cfg.step_yx;
      pyr1_in = $signed({1'b0, in_row}) * cfg.step_yy;
   end

   always_comb begin
      sx2_in = SW'(cfg.origin_x) + SW'(pxc1_ff) + SW'(pxr1_ff);
      sy2_in = SW'(cfg.origin_y) + SW'(pyc1_ff) + SW'(pyr1_ff);
   end

   // Effective source size, zero counts as one and sizes above the maximum are capped
   always_comb begin
      if (cfg.source_width == 9'd0)
         w_eff = 9'd1;
      else if (32'(cfg.source_width) > MAX_WIDTH)
         w_eff = 9'(MAX_WIDTH);
      else
         w_eff = cfg.source_width;
      if (cfg.source_height == 9'd0)
         h_eff = 9'd1;
      else if (32'(cfg.source_height) > MAX_HEIGHT)
         h_eff = 9'(MAX_HEIGHT);
      else
         h_eff = cfg.source_height;
      hi_x = $signed(SW'(w_eff - 9'd1) << FRAC_BITS);
      hi_y = $signed(SW'(h_eff - 9'd1) << FRAC_BITS);
   end

   always_comb begin
      cx = clamp_coord(sx2_ff, hi_x);
      cy = clamp_coord(sy2_ff, hi_y);
      fx = cx[FRAC_BITS-1:0];
      fy = cy[FRAC_BITS-1:0];
      if (cmd2_ff == CMD_SAMPLE) begin
         x3_in = cx[FRAC_BITS +: XW];
         y3_in = cy[FRAC_BITS +: YW];
      end else begin
         x3_in = XW'(col2_ff);
         y3_in = YW'(row2_ff);
      end
      ctl3_in.valid = v2_ff && (cmd2_ff == CMD_SAMPLE);
      ctl3_in.hit   = (fx == '0) && (fy == '0);
      ctl3_in.x_odd = x3_in[0];
      ctl3_in.y_odd = y3_in[0];
      ctl3_in.dx    = 16'({fx, 16'h0000} >> FRAC_BITS);
      ctl3_in.dy    = 16'({fy, 16'h0000} >> FRAC_BITS);
      we3_in = v2_ff && (cmd2_ff == CMD_WRITE) &&
               (32'(col2_ff) < MAX_WIDTH) && (32'(row2_ff) < MAX_HEIGHT);
   end

   always_ff @(posedge clock) begin
      cmd1_ff <= in_command;
      col1_ff <= in_column;
      row1_ff <= in_row;
      pix1_ff <= in_pixel;
      pxc1_ff <= pxc1_in;
      pxr1_ff <= pxr1_in;
      pyc1_ff <= pyc1_in;
      pyr1_ff <= pyr1_in;
      cmd2_ff <= cmd1_ff;
      col2_ff <= col1_ff;
      row2_ff <= row1_ff;
      pix2_ff <= pix1_ff;
      sx2_ff  <= sx2_in;
      sy2_ff  <= sy2_in;
      x3_ff   <= x3_in;
      y3_ff   <= y3_in;
      pix3_ff <= pix2_ff;
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         we3_ff        <= 1'b0;
      end else begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         ctl3_ff <= ctl3_in;
         we3_ff  <= we3_in;
      end
   end

   assign out_ctl   = ctl3_ff;
   assign out_write = we3_ff;
   assign out_x     = x3_ff;
   assign out_y     = y3_ff;
   assign out_pixel = pix3_ff;

endmodule

`default_nettype wire

FILE: hdl/awb_store.sv
// Frame store split into four banks by column and row parity.
`default_nettype none

module awb_store #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire awb_pkg::ctl_type             in_ctl,
   input  wire logic                         in_write,
   input  wire logic [$clog2(MAX_WIDTH)-1:0] in_x,
   input  wire logic [$clog2(MAX_HEIGHT)-1:0] in_y,
   input  wire awb_pkg::pixel_type           in_pixel,
   output awb_pkg::ctl_type                  out_ctl,
   output awb_pkg::pixel_type                out_q [4]
);
   import awb_pkg::*;

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int XHW   = (XW > 1) ? XW - 1 : 1;
   localparam int YHW   = (YW > 1) ? YW - 1 : 1;
   localparam int DEPTH = 1 << (XHW + YHW);

   ctl_type ctl_ff;

   // Bank b holds pixels with column parity b[0] and row parity b[1]
   for (genvar b = 0; b < 4; b++) begin : g_bank
      pixel_type             bank_mem_ff [DEPTH];
      pixel_type             q_ff;
      logic [XW:0]           rcol;
      logic [YW:0]           rrow;
      logic [XHW+YHW-1:0]    raddr, waddr;
      logic                  wen;

      always_comb begin
         rcol  = {1'b0, in_x} + (XW+1)'(in_x[0] != 1'(b));
         rrow  = {1'b0, in_y} + (YW+1)'(in_y[0] != 1'(b >> 1));
         raddr = {YHW'(rrow >> 1), XHW'(rcol >> 1)};
         waddr = {YHW'(in_y >> 1), XHW'(in_x >> 1)};
         wen   = in_write && (in_x[0] == 1'(b)) && (in_y[0] == 1'(b >> 1));
      end

      always_ff @(posedge clock) begin
         if (wen)
            bank_mem_ff[waddr] <= in_pixel;
         q_ff <= bank_mem_ff[raddr];
      end

      assign out_q[b] = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         ctl_ff.valid <= 1'b0;
      else
         ctl_ff <= in_ctl;
   end

   assign out_ctl = ctl_ff;

endmodule

`default_nettype wire

FILE: hdl/awb_blend.sv
// Bilinear weights and premultiplied alpha sums over the four neighbors.
`default_nettype none

module awb_blend (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire awb_pkg::ctl_type          in_ctl,
   input  wire awb_pkg::pixel_type        in_q [4],
   output awb_pkg::side_type              out_side,
   output logic [awb_pkg::NUM_W-1:0]      out_num [3],
   output logic [awb_pkg::WA_W-1:0]       out_den
);
   import awb_pkg::*;

   // Stage 1: neighbor select, weights
   side_type         s1_ff, s1_in;
   pixel_type        p1_ff [4], p1_in [4];
   logic [WGT_W-1:0] w1_ff [4], w1_in [4];

   // Stage 2: weight times alpha
   side_type         s2_ff;
   pixel_type        p2_ff [4];
   logic [WA_W-1:0]  wa2_ff [4], wa2_in [4];

   // Stage 3: colour products, alpha pair sums
   side_type          s3_ff;
   logic [PROD_W-1:0] c3_ff [4][3], c3_in [4][3];
   logic [WA_W-1:0]   a3_ff [2], a3_in [2];

   // Stage 4: colour pair sums, alpha total
   side_type          s4_ff;
   logic [PROD_W-1:0] c4_ff [2][3], c4_in [2][3];
   logic [WA_W-1:0]   a4_ff, a4_in;

   // Stage 5: colour totals, output alpha
   side_type          s5_ff, s5_in;
   logic [PROD_W-1:0] c5_ff [3], c5_in [3];
   logic [WA_W-1:0]   a5_ff;
   logic [16:0]       alpha_round;

   // Stage 6: rounded dividend
   side_type          s6_ff;
   logic [NUM_W-1:0]  n6_ff [3], n6_in [3];
   logic [WA_W-1:0]   a6_ff;

   always_comb begin
      logic [1:0]  sel;
      logic [16:0] wx, wy;
      logic        gate;
      for (int k = 0; k < 4; k++) begin
         sel  = {in_ctl.y_odd ^ (k >= 2), in_ctl.x_odd ^ ((k & 1) == 1)};
         gate = (((k & 1) == 1) && (in_ctl.dx == 16'd0)) ||
                ((k >= 2) && (in_ctl.dy == 16'd0));
         wx   = ((k & 1) == 1) ? {1'b0, in_ctl.dx} : 17'h10000 - {1'b0, in_ctl.dx};
         wy   = (k >= 2) ? {1'b0, in_ctl.dy} : 17'h10000 - {1'b0, in_ctl.dy};
         p1_in[k] = gate ? '0 : in_q[sel];
         w1_in[k] = WGT_W'(wx) * WGT_W'(wy);
      end
      s1_in       = '0;
      s1_in.valid = in_ctl.valid;
      s1_in.hit   = in_ctl.hit;
      s1_in.pix   = in_q[{in_ctl.y_odd, in_ctl.x_odd}];
   end

   always_comb begin
      for (int k = 0; k < 4; k++)
         wa2_in[k] = WA_W'(w1_ff[k]) * WA_W'(p1_ff[k].alpha);
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         c3_in[k][0] = PROD_W'(wa2_ff[k]) * PROD_W'(p2_ff[k].red);
         c3_in[k][1] = PROD_W'(wa2_ff[k]) * PROD_W'(p2_ff[k].green);
         c3_in[k][2] = PROD_W'(wa2_ff[k]) * PROD_W'(p2_ff[k].blue);
      end
      a3_in[0] = wa2_ff[0] + wa2_ff[1];
      a3_in[1] = wa2_ff[2] + wa2_ff[3];
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         c4_in[0][c] = c3_ff[0][c] + c3_ff[1][c];
         c4_in[1][c] = c3_ff[2][c] + c3_ff[3][c];
      end
      a4_in = a3_ff[0] + a3_ff[1];
   end

   // Alpha rounds to nearest, zero alpha marks transparent black
   always_comb begin
      for (int c = 0; c < 3; c++)
         c5_in[c] = c4_ff[0][c] + c4_ff[1][c];
      alpha_round = 17'((a4_ff + (WA_W'(1) << 31)) >> 32);
      s5_in       = s4_ff;
      s5_in.zero  = (a4_ff == '0);
      s5_in.alpha = alpha_round[16] ? 16'hFFFF : alpha_round[15:0];
   end

   always_comb begin
      for (int c = 0; c < 3; c++)
         n6_in[c] = NUM_W'(c5_ff[c]) + NUM_W'(a5_ff >> 1);
   end

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      w1_ff  <= w1_in;
      p2_ff  <= p1_ff;
      wa2_ff <= wa2_in;
      c3_ff  <= c3_in;
      a3_ff  <= a3_in;
      c4_ff  <= c4_in;
      a4_ff  <= a4_in;
      c5_ff  <= c5_in;
      a5_ff  <= a4_ff;
      n6_ff  <= n6_in;
      a6_ff  <= a5_ff;
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
         s5_ff <= s5_in;
         s6_ff <= s5_ff;
      end
   end

   assign out_side = s6_ff;
   assign out_num  = n6_ff;
   assign out_den  = a6_ff;

endmodule

`default_nettype wire

FILE: hdl/awb_div.sv
// Pipelined restoring divider, one quotient bit per stage, three colour lanes.
`default_nettype none

module awb_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire awb_pkg::side_type         in_side,
   input  wire logic [awb_pkg::NUM_W-1:0] in_num [3],
   input  wire logic [awb_pkg::WA_W-1:0]  in_den,
   output awb_pkg::side_type              out_side,
   output logic [awb_pkg::QBITS-1:0]      out_quo [3]
);
   import awb_pkg::*;

   side_type         side_ff [QBITS], side_in [QBITS];
   logic [WA_W-1:0]  den_ff [QBITS], den_in [QBITS];
   logic [NUM_W-1:0] rem_ff [QBITS][3], rem_in [QBITS][3];
   logic [QBITS-1:0] quo_ff [QBITS][3], quo_in [QBITS][3];

   // Stage s decides quotient bit QBITS-1-s
   always_comb begin
      logic [NUM_W-1:0] src_rem;
      logic [QBITS-1:0] src_quo;
      logic [WA_W-1:0]  src_den;
      logic [NUM_W:0]   diff;
      for (int s = 0; s < QBITS; s++) begin
         src_den    = (s == 0) ? in_den : den_ff[(s == 0) ? 0 : s - 1];
         den_in[s]  = src_den;
         side_in[s] = (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s - 1];
         for (int c = 0; c < 3; c++) begin
            src_rem = (s == 0) ? in_num[c] : rem_ff[(s == 0) ? 0 : s - 1][c];
            src_quo = (s == 0) ? '0 : quo_ff[(s == 0) ? 0 : s - 1][c];
            diff    = {1'b0, src_rem} - ((NUM_W+1)'(src_den) << (QBITS - 1 - s));
            if (!diff[NUM_W]) begin
               rem_in[s][c] = diff[NUM_W-1:0];
               quo_in[s][c] = src_quo | (QBITS'(1) << (QBITS - 1 - s));
            end else begin
               rem_in[s][c] = src_rem;
               quo_in[s][c] = src_quo;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         for (int s = 0; s < QBITS; s++)
            side_ff[s].valid <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
   end

   assign out_side = side_ff[QBITS-1];
   assign out_quo  = quo_ff[QBITS-1];

endmodule

`default_nettype wire

FILE: tb/awb_checker.sv
// Checker for the affine warp bilinear sampler: tracks config and frame store, predicts, compares.
`timescale 1ns / 1ps

module awb_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_start,
   input  wire logic                            busy,
   input  wire logic                            req_command,
   input  wire logic [7:0]                      req_column,
   input  wire logic [7:0]                      req_row,
   input  wire logic [15:0]                     req_red_in,
   input  wire logic [15:0]                     req_green_in,
   input  wire logic [15:0]                     req_blue_in,
   input  wire logic [15:0]                     req_alpha_in,
   input  wire logic                            csr_write,
   input  wire logic [awb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [awb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                            rsp_strobe,
   input  wire logic [15:0]                     rsp_red_out,
   input  wire logic [15:0]                     rsp_green_out,
   input  wire logic [15:0]                     rsp_blue_out,
   input  wire logic [15:0]                     rsp_alpha_out,
   output int                                   errors,
   output int                                   pending,
   output int                                   checked
);
   import awb_pkg::*;

   cfg_type     cur_cfg;
   logic [63:0] frame [0:65535];
   pixel_type   expected_pixels[$];

   initial begin
      errors  = 0;
      pending = 0;
      checked = 0;
   end

   function automatic int clamp_size(logic [8:0] raw);
      if (raw == 0) return 1;
      if (raw > 256) return 256;
      return int'(raw);
   endfunction

   // Map one axis: subtract a half, clamp to the image, split into taps and fraction.
   function automatic void map_axis(longint v, int len, output int i0, output int i1,
                                    output logic [15:0] f);
      longint hi;
      hi = longint'(len - 1) <<< 16;
      v  = v - 32768;
      if (v < 0) v = 0;
      if (v > hi) v = hi;
      i0 = int'(v >>> 16);
      f  = v[15:0];
      i1 = (i0 + 1 < len) ? i0 + 1 : len - 1;
   endfunction

   // Source taps of an output pixel under the current map; also used by stimulus.
   function automatic void sample_taps(input logic [7:0] col, input logic [7:0] row,
                                       output int x0, output int x1, output int y0,
                                       output int y1, output logic [15:0] fx,
                                       output logic [15:0] fy);
      longint sx, sy;
      sx = longint'(cur_cfg.origin_x) + longint'(col) * longint'(cur_cfg.step_xx)
         + longint'(row) * longint'(cur_cfg.step_xy);
      sy = longint'(cur_cfg.origin_y) + longint'(col) * longint'(cur_cfg.step_yx)
         + longint'(row) * longint'(cur_cfg.step_yy);
      map_axis(sx, clamp_size(cur_cfg.source_width), x0, x1, fx);
      map_axis(sy, clamp_size(cur_cfg.source_height), y0, y1, fy);
   endfunction

   // Premultiplied bilinear blend returned as straight color; an exact hit returns the stored pixel.
   function automatic pixel_type warp_pixel(logic [7:0] col, logic [7:0] row);
      int          x0, x1, y0, y1;
      int          xs[2], ys[2];
      logic [15:0] fx, fy;
      logic [63:0] wx[2], wy[2], wa, sum_a, q;
      logic [63:0] sum_c[3];
      pixel_type   px, res;
      sample_taps(col, row, x0, x1, y0, y1, fx, fy);
      if (fx == 0 && fy == 0) return pixel_type'(frame[y0 * 256 + x0]);
      xs[0] = x0; xs[1] = x1; ys[0] = y0; ys[1] = y1;
      wx[0] = 65536 - fx; wx[1] = fx;
      wy[0] = 65536 - fy; wy[1] = fy;
      sum_a = 0;
      for (int k = 0; k < 3; k++) sum_c[k] = 0;
      for (int j = 0; j < 2; j++) begin
         for (int i = 0; i < 2; i++) begin
            px = pixel_type'(frame[ys[j] * 256 + xs[i]]);
            wa = wx[i] * wy[j] * 64'(px.alpha);
            sum_a += wa;
            sum_c[0] += wa * 64'(px.red);
            sum_c[1] += wa * 64'(px.green);
            sum_c[2] += wa * 64'(px.blue);
         end
      end
      res = '0;
      if (sum_a == 0) return res;
      for (int k = 0; k < 3; k++) begin
         q = (sum_c[k] + sum_a / 2) / sum_a;
         if (q > 64'hFFFF) q = 64'hFFFF;
         case (k)
            0: res.red = q[15:0];
            1: res.green = q[15:0];
            default: res.blue = q[15:0];
         endcase
      end
      q = (sum_a + (64'd1 << 31)) >> 32;
      res.alpha = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         cur_cfg.origin_x      = 25'sd32768;
         cur_cfg.origin_y      = 25'sd32768;
         cur_cfg.step_xx       = 21'sd65536;
         cur_cfg.step_xy       = '0;
         cur_cfg.step_yx       = '0;
         cur_cfg.step_yy       = 21'sd65536;
         cur_cfg.source_width  = 9'd256;
         cur_cfg.source_height = 9'd256;
         expected_pixels.delete();
      end else begin
         // Result side: compare against the oldest prediction
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result transaction");
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               checked++;
               if (rsp_red_out !== want.red) begin
                  $error("red_out: expected %h actual %h", want.red, rsp_red_out);
                  errors++;
               end
               if (rsp_green_out !== want.green) begin
                  $error("green_out: expected %h actual %h", want.green, rsp_green_out);
                  errors++;
               end
               if (rsp_blue_out !== want.blue) begin
                  $error("blue_out: expected %h actual %h", want.blue, rsp_blue_out);
                  errors++;
               end
               if (rsp_alpha_out !== want.alpha) begin
                  $error("alpha_out: expected %h actual %h", want.alpha, rsp_alpha_out);
                  errors++;
               end
            end
         end
         // Config writes
         if (csr_write) begin
            case (csr_index)
               REG_ORIGIN_X:      cur_cfg.origin_x = csr_data[24:0];
               REG_ORIGIN_Y:      cur_cfg.origin_y = csr_data[24:0];
               REG_STEP_XX:       cur_cfg.step_xx = csr_data[20:0];
               REG_STEP_XY:       cur_cfg.step_xy = csr_data[20:0];
               REG_STEP_YX:       cur_cfg.step_yx = csr_data[20:0];
               REG_STEP_YY:       cur_cfg.step_yy = csr_data[20:0];
               REG_SOURCE_WIDTH:  cur_cfg.source_width = csr_data[8:0];
               REG_SOURCE_HEIGHT: cur_cfg.source_height = csr_data[8:0];
               default: ;
            endcase
         end
         // Input side: writes update the store, samples queue a prediction
         if (req_start && !busy) begin
            if (req_command == CMD_WRITE)
               frame[{req_row, req_column}] =
                  {req_alpha_in, req_blue_in, req_green_in, req_red_in};
            else
               expected_pixels.push_back(warp_pixel(req_column, req_row));
         end
      end
      pending = expected_pixels.size();
   end

endmodule

FILE: tb/tb.sv
// Testbench top for the affine warp bilinear sampler: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import awb_pkg::*;

   localparam int NUM_ITEMS  = 1650;
   localparam int QUIET_FROM = 1450;
   localparam int WD_LIMIT   = 4000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_start = 1'b0;
   logic                   busy;
   logic                   req_command = CMD_WRITE;
   logic [7:0]             req_column = '0;
   logic [7:0]             req_row = '0;
   logic [15:0]            req_red_in = '0;
   logic [15:0]            req_green_in = '0;
   logic [15:0]            req_blue_in = '0;
   logic [15:0]            req_alpha_in = '0;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_ORIGIN_X;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   logic                   rsp_strobe;
   logic [15:0]            rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   int                     errors, pending, checked;

   bit      written [0:65535];
   int      items = 0;
   int      phases = 0;
   bit      gaps_on = 1'b1;
   int      quiet_cycles = 0;
   cfg_type map_cfg;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   affine_warp_bilinear_sampler u_top (.*);

   awb_checker u_chk (.*);

   // Watchdog: cycles without any accepted transaction or result
   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int eff_size(logic [8:0] raw);
      if (raw == 0) return 1;
      if (raw > 256) return 256;
      return int'(raw);
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type p;
      p = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: p.alpha = '0;
         1: p.alpha = 16'hFFFF;
         2: p = '0;
         3: p = '1;
         default: ;
      endcase
      return p;
   endfunction

   // One input transaction, with an optional idle burst ahead of it
   task automatic send(logic cmd, logic [7:0] col, logic [7:0] row, pixel_type p);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_start    <= 1'b1;
      req_command  <= cmd;
      req_column   <= col;
      req_row      <= row;
      req_red_in   <= p.red;
      req_green_in <= p.green;
      req_blue_in  <= p.blue;
      req_alpha_in <= p.alpha;
      do @(posedge clock); while (busy);
      items++;
      if (cmd == CMD_WRITE) written[{row, col}] = 1'b1;
   endtask

   // Hold off until every sample has returned and the pipeline is empty
   task automatic drain();
      req_start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic load_map(cfg_type c);
      logic [CSR_DATA_W-1:0] vals[8];
      vals[REG_ORIGIN_X]      = c.origin_x;
      vals[REG_ORIGIN_Y]      = c.origin_y;
      vals[REG_STEP_XX]       = CSR_DATA_W'(c.step_xx);
      vals[REG_STEP_XY]       = CSR_DATA_W'(c.step_xy);
      vals[REG_STEP_YX]       = CSR_DATA_W'(c.step_yx);
      vals[REG_STEP_YY]       = CSR_DATA_W'(c.step_yy);
      vals[REG_SOURCE_WIDTH]  = CSR_DATA_W'(c.source_width);
      vals[REG_SOURCE_HEIGHT] = CSR_DATA_W'(c.source_height);
      drain();
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data  <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      @(posedge clock);
      map_cfg = c;
   endtask

   task automatic write_px(int col, int row);
      send(CMD_WRITE, 8'(col), 8'(row), rand_pixel());
   endtask

   // Sample a random output pixel whose taps are all written; else write inside the image
   task automatic try_sample();
      logic [7:0]  col, row;
      int          x0, x1, y0, y1;
      logic [15:0] fx, fy;
      for (int t = 0; t < 8; t++) begin
         col = $urandom;
         row = $urandom;
         u_chk.sample_taps(col, row, x0, x1, y0, y1, fx, fy);
         if (written[y0 * 256 + x0] && written[y0 * 256 + x1] &&
             written[y1 * 256 + x0] && written[y1 * 256 + x1]) begin
            send(CMD_SAMPLE, col, row, rand_pixel());
            return;
         end
      end
      write_px($urandom_range(0, eff_size(map_cfg.source_width) - 1),
               $urandom_range(0, eff_size(map_cfg.source_height) - 1));
   endtask

   function automatic logic [8:0] pick_size(int mode);
      logic [8:0] opts[5] = '{9'd0, 9'd1, 9'd256, 9'd257, 9'd511};
      if (mode == 0) return opts[$urandom_range(0, 4)];
      if (mode == 1) return 9'($urandom_range(1, 8));
      if (mode == 2) return 9'($urandom_range(9, 511));
      return 9'($urandom);
   endfunction

   function automatic logic signed [20:0] pick_step(int mode);
      if (mode == 0) return $urandom_range(0, 1) ? 21'sh0FFFFF : 21'sh100000;
      if (mode == 1) return 21'($signed($urandom_range(0, 262144)) - 131072);
      if (mode == 2) return 21'($signed($urandom_range(0, 512)) - 256);
      return 21'($urandom);
   endfunction

   task automatic run_phase(int mode);
      cfg_type c;
      int      ew, eh, bx, by;
      c.source_width  = pick_size(mode);
      c.source_height = pick_size(mode);
      c.step_xx = pick_step(mode);
      c.step_xy = pick_step(mode);
      c.step_yx = pick_step(mode);
      c.step_yy = pick_step(mode);
      ew = eff_size(c.source_width);
      eh = eff_size(c.source_height);
      bx = (ew > 4) ? $urandom_range(0, ew - 4) : 0;
      by = (eh > 4) ? $urandom_range(0, eh - 4) : 0;
      case (mode)
         0: begin
            c.origin_x = $urandom_range(0, 1) ? 25'sh0FFFFFF : 25'sh1000000;
            c.origin_y = $urandom_range(0, 1) ? 25'sh0FFFFFF : 25'sh1000000;
         end
         1: begin
            c.origin_x = 25'($signed($urandom_range(0, 524288)) - 262144);
            c.origin_y = 25'($signed($urandom_range(0, 524288)) - 262144);
         end
         2: begin
            c.origin_x = 25'(((bx + 1) << 16) + $urandom_range(0, 65535));
            c.origin_y = 25'(((by + 1) << 16) + $urandom_range(0, 65535));
         end
         default: begin
            c.origin_x = 25'($urandom);
            c.origin_y = 25'($urandom);
         end
      endcase
      load_map(c);
      // Fill small images whole; big ones get the window and the four corners
      if (ew * eh <= 64) begin
         for (int r = 0; r < eh; r++)
            for (int k = 0; k < ew; k++) write_px(k, r);
      end else begin
         for (int r = 0; r < 4 && by + r < eh; r++)
            for (int k = 0; k < 4 && bx + k < ew; k++) write_px(bx + k, by + r);
         for (int r = 0; r < 2; r++)
            for (int k = 0; k < 2; k++) begin
               write_px(k < ew ? k : ew - 1, r < eh ? r : eh - 1);
               write_px(ew - 1 - (k < ew ? k : 0), r < eh ? r : eh - 1);
               write_px(k < ew ? k : ew - 1, eh - 1 - (r < eh ? r : 0));
               write_px(ew - 1 - (k < ew ? k : 0), eh - 1 - (r < eh ? r : 0));
            end
      end
      for (int n = 0; n < 110 && items < NUM_ITEMS; n++) begin
         if (items >= QUIET_FROM) gaps_on = 1'b0;
         case ($urandom_range(0, 9))
            0: write_px($urandom_range(0, 255), $urandom_range(0, 255));
            1, 2: write_px($urandom_range(0, ew - 1), $urandom_range(0, eh - 1));
            default: try_sample();
         endcase
      end
      phases++;
   endtask

   initial begin
      cfg_type c;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of the pixel fields at the default identity map
      send(CMD_WRITE, 8'd0, 8'd0, '1);
      send(CMD_WRITE, 8'd1, 8'd0, '0);
      send(CMD_WRITE, 8'd0, 8'd1, {16'hFFFF, 16'h0000, 16'h8000, 16'h1234});
      send(CMD_WRITE, 8'd1, 8'd1, {16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      send(CMD_WRITE, 8'd2, 8'd0, {16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF});
      send(CMD_WRITE, 8'd3, 8'd0, {16'h0000, 16'h1111, 16'h2222, 16'h3333});
      send(CMD_WRITE, 8'd2, 8'd1, {16'h0000, 16'hFFFF, 16'h0001, 16'h0000});
      send(CMD_WRITE, 8'd3, 8'd1, {16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF});
      send(CMD_WRITE, 8'd254, 8'd254, rand_pixel());
      send(CMD_WRITE, 8'd255, 8'd254, rand_pixel());
      send(CMD_WRITE, 8'd254, 8'd255, rand_pixel());
      send(CMD_WRITE, 8'd255, 8'd255, {16'hFFFF, 16'h0001, 16'hFFFE, 16'h8001});
      // Exact hits return the stored pixel
      send(CMD_SAMPLE, 8'd0, 8'd0, '0);
      send(CMD_SAMPLE, 8'd1, 8'd1, '0);
      send(CMD_SAMPLE, 8'd255, 8'd255, '1);
      // Quarter-pixel shift: blending, zero alpha, clamping at the far edge
      c = '{origin_x: 25'sh0C000, origin_y: 25'sh14000, step_xx: 21'sh10000,
            step_xy: '0, step_yx: '0, step_yy: 21'sh10000,
            source_width: 9'd256, source_height: 9'd256};
      load_map(c);
      send(CMD_SAMPLE, 8'd0, 8'd0, '0);
      send(CMD_SAMPLE, 8'd2, 8'd0, '0);
      send(CMD_SAMPLE, 8'd255, 8'd255, '0);

      // Random phases cycling through extreme, small, windowed and raw maps
      while (items < NUM_ITEMS) run_phase(phases % 4);

      drain();
      $display("Covered %0d transactions over %0d map settings; %0d samples checked.",
               items, phases + 1, checked);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
